>>> rtl/core/mpga_pkg.sv
`default_nettype none

package mpga_pkg;

  // Default size of the register file of qubits
  localparam int MAX_QUBITS_DEF  = 20;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Field widths
  localparam int PAIR_W  = 19;
  localparam int ROW_W   = 20;
  localparam int AMP_W   = 16;
  localparam int COEF_W  = 32;
  localparam int CNT_W   = 5;
  localparam int WORK_W  = 32;
  localparam int PROD_W  = 2 * AMP_W;
  localparam int ACC_W   = PROD_W + 3;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // Register reset values: identity gate on one qubit
  localparam logic [CNT_W-1:0]  QUBIT_COUNT_RST = 5'd1;
  localparam logic [CNT_W-1:0]  TARGET_RST      = 5'd0;
  localparam logic [COEF_W-1:0] COEF_ONE        = 32'h4000_0000;
  localparam logic [COEF_W-1:0] COEF_ZERO       = 32'h0000_0000;

  // Register map, word index
  typedef enum logic [2:0] {
    REG_QUBIT_COUNT  = 3'd0,
    REG_TARGET_QUBIT = 3'd1,
    REG_COEF_00      = 3'd2,
    REG_COEF_01      = 3'd3,
    REG_COEF_10      = 3'd4,
    REG_COEF_11      = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0] qubit_count;
    logic [CNT_W-1:0] tgt_pos;
  } geom_t;

  typedef struct packed {
    logic [COEF_W-1:0] c00;
    logic [COEF_W-1:0] c01;
    logic [COEF_W-1:0] c10;
    logic [COEF_W-1:0] c11;
  } gate_t;

  // Classified pair, as handed from front to back
  typedef struct packed {
    logic                    bad;
    logic [ROW_W-1:0]        row0;
    logic [ROW_W-1:0]        row1;
    logic signed [AMP_W-1:0] a0r;
    logic signed [AMP_W-1:0] a0i;
    logic signed [AMP_W-1:0] a1r;
    logic signed [AMP_W-1:0] a1i;
  } item_t;

endpackage

`default_nettype wire

>>> rtl/core/mpga_pair_if.sv
`default_nettype none

interface mpga_pair_if;
  logic                             valid;
  logic                             ready;
  logic [mpga_pkg::PAIR_W-1:0]      pair_index;
  logic signed [mpga_pkg::AMP_W-1:0] amp0_re;
  logic signed [mpga_pkg::AMP_W-1:0] amp0_im;
  logic signed [mpga_pkg::AMP_W-1:0] amp1_re;
  logic signed [mpga_pkg::AMP_W-1:0] amp1_im;

  modport source (output valid, pair_index, amp0_re, amp0_im, amp1_re, amp1_im,
                  input ready);
  modport sink (input valid, pair_index, amp0_re, amp0_im, amp1_re, amp1_im,
                output ready);
endinterface

`default_nettype wire

>>> rtl/core/mpga_res_if.sv
`default_nettype none

interface mpga_res_if;
  logic                             valid;
  logic                             ready;
  logic [mpga_pkg::ROW_W-1:0]       phys_row0;
  logic [mpga_pkg::ROW_W-1:0]       phys_row1;
  logic signed [mpga_pkg::AMP_W-1:0] new0_re;
  logic signed [mpga_pkg::AMP_W-1:0] new0_im;
  logic signed [mpga_pkg::AMP_W-1:0] new1_re;
  logic signed [mpga_pkg::AMP_W-1:0] new1_im;
  logic                             index_error;

  modport source (output valid, phys_row0, phys_row1, new0_re, new0_im, new1_re,
                  new1_im, index_error, input ready);
  modport sink (input valid, phys_row0, phys_row1, new0_re, new0_im, new1_re,
                new1_im, index_error, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mpga_front.sv
`default_nettype none

module mpga_front #(
  parameter int MAX_QUBITS = mpga_pkg::MAX_QUBITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  mpga_pair_if.sink            pairs,
  input  wire mpga_pkg::geom_t geom,
  output mpga_pkg::item_t      item,
  output logic                 item_valid,
  input  wire logic            item_ready
);

  localparam int W = mpga_pkg::WORK_W;

  // Interleave: low bits to even positions, remaining high bits to odd ones
  function automatic logic [mpga_pkg::ROW_W-1:0] morton_map(
    input logic [W-1:0]                 row,
    input logic [mpga_pkg::CNT_W-1:0]   lo_bits
  );
    logic [mpga_pkg::ROW_W-1:0] m;
    logic [W-1:0]               hi;
    hi = row >> lo_bits;
    m  = '0;
    for (int j = 0; j < mpga_pkg::ROW_W / 2; j++) begin
      m[2*j]   = (mpga_pkg::CNT_W'(j) < lo_bits) ? row[j] : 1'b0;
      m[2*j+1] = hi[j];
    end
    return m;
  endfunction

  logic [mpga_pkg::CNT_W-1:0] n;
  logic [mpga_pkg::CNT_W-1:0] t;
  logic [mpga_pkg::CNT_W-1:0] nm1;
  logic [mpga_pkg::CNT_W-1:0] lo_bits;
  logic                       cfg_bad;
  logic                       range_bad;
  logic                       bad;
  logic [W-1:0]               p_w;
  logic [W-1:0]               below_mask;
  logic [W-1:0]               i0;
  logic [W-1:0]               i1;
  logic [mpga_pkg::CNT_W:0]   t_up;
  mpga_pkg::item_t            item_next;
  logic                       fire;

  // Classification of the incoming pair
  always_comb begin
    n         = geom.qubit_count;
    t         = geom.tgt_pos;
    nm1       = n - mpga_pkg::CNT_W'(1);
    lo_bits   = mpga_pkg::CNT_W'(({1'b0, n} + 6'd1) >> 1);
    cfg_bad   = (n == '0) || ({1'b0, n} > (mpga_pkg::CNT_W + 1)'(MAX_QUBITS)) || (t >= n);
    range_bad = (nm1 < mpga_pkg::CNT_W'(mpga_pkg::PAIR_W)) && ((pairs.pair_index >> nm1) != '0);
    bad       = cfg_bad || range_bad;

    // Insert a zero at the target bit, then set it for the partner row
    p_w        = W'(pairs.pair_index);
    below_mask = (W'(1) << t) - W'(1);
    t_up       = {1'b0, t} + 6'd1;
    i0         = ((p_w >> t) << t_up) | (p_w & below_mask);
    i1         = i0 | (W'(1) << t);

    item_next.bad  = bad;
    item_next.row0 = bad ? '0 : morton_map(i0, lo_bits);
    item_next.row1 = bad ? '0 : morton_map(i1, lo_bits);
    item_next.a0r  = pairs.amp0_re;
    item_next.a0i  = pairs.amp0_im;
    item_next.a1r  = pairs.amp1_re;
    item_next.a1i  = pairs.amp1_im;
  end

  assign pairs.ready = !item_valid || item_ready;
  assign fire        = pairs.valid && pairs.ready;

  // Stage register toward the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (fire) begin
      item_valid <= 1'b1;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mpga_queue.sv
`default_nettype none

module mpga_queue #(
  parameter int DEPTH = mpga_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire mpga_pkg::item_t push_item,
  input  wire logic            push_valid,
  output logic                 push_ready,
  output mpga_pkg::item_t      pop_item,
  output logic                 pop_valid,
  input  wire logic            pop_ready
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  mpga_pkg::item_t  slots [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mpga_back.sv
`default_nettype none

module mpga_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire mpga_pkg::item_t in_item,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire mpga_pkg::gate_t gate,
  mpga_res_if.source           results
);

  localparam int AW = mpga_pkg::AMP_W;
  localparam int PW = mpga_pkg::PROD_W;
  localparam int CW = mpga_pkg::ACC_W;
  localparam int QW = CW - 13;

  localparam logic signed [QW-1:0] SAT_HI = QW'(32767);
  localparam logic signed [QW-1:0] SAT_LO = -QW'(32768);

  // Round half up to Q1.15, then saturate
  function automatic logic signed [AW-1:0] round_sat(input logic signed [CW-1:0] acc);
    logic signed [CW:0]   biased;
    logic signed [QW-1:0] q;
    biased = (CW + 1)'(acc) + (CW + 1)'(8192);
    q      = QW'(biased >>> 14);
    if (q > SAT_HI) begin
      return AW'(SAT_HI);
    end else if (q < SAT_LO) begin
      return AW'(SAT_LO);
    end
    return AW'(q);
  endfunction

  logic                    adv;
  logic                    s1_valid;
  mpga_pkg::item_t         s1_item;
  logic signed [PW-1:0]    s1_prod [4][4];
  logic                    s2_valid;
  mpga_pkg::item_t         s2_item;
  logic signed [CW-1:0]    s2_acc [4];
  logic                    s3_valid;

  logic signed [AW-1:0] g00r, g00i, g01r, g01i, g10r, g10i, g11r, g11i;

  assign g00r = $signed(gate.c00[31:16]);
  assign g00i = $signed(gate.c00[15:0]);
  assign g01r = $signed(gate.c01[31:16]);
  assign g01i = $signed(gate.c01[15:0]);
  assign g10r = $signed(gate.c10[31:16]);
  assign g10i = $signed(gate.c10[15:0]);
  assign g11r = $signed(gate.c11[31:16]);
  assign g11i = $signed(gate.c11[15:0]);

  // Whole pipe moves when the output register is free or taken
  assign adv      = !s3_valid || results.ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Stage 1: sixteen partial products, rows are output components
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item       <= in_item;
      s1_prod[0][0] <= g00r * in_item.a0r;
      s1_prod[0][1] <= g00i * in_item.a0i;
      s1_prod[0][2] <= g01r * in_item.a1r;
      s1_prod[0][3] <= g01i * in_item.a1i;
      s1_prod[1][0] <= g00r * in_item.a0i;
      s1_prod[1][1] <= g00i * in_item.a0r;
      s1_prod[1][2] <= g01r * in_item.a1i;
      s1_prod[1][3] <= g01i * in_item.a1r;
      s1_prod[2][0] <= g10r * in_item.a0r;
      s1_prod[2][1] <= g10i * in_item.a0i;
      s1_prod[2][2] <= g11r * in_item.a1r;
      s1_prod[2][3] <= g11i * in_item.a1i;
      s1_prod[3][0] <= g10r * in_item.a0i;
      s1_prod[3][1] <= g10i * in_item.a0r;
      s1_prod[3][2] <= g11r * in_item.a1i;
      s1_prod[3][3] <= g11i * in_item.a1r;
    end
  end

  // Stage 2: exact sums; real parts subtract the imaginary products
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_item   <= s1_item;
      s2_acc[0] <= CW'(s1_prod[0][0]) - CW'(s1_prod[0][1])
                 + CW'(s1_prod[0][2]) - CW'(s1_prod[0][3]);
      s2_acc[1] <= CW'(s1_prod[1][0]) + CW'(s1_prod[1][1])
                 + CW'(s1_prod[1][2]) + CW'(s1_prod[1][3]);
      s2_acc[2] <= CW'(s1_prod[2][0]) - CW'(s1_prod[2][1])
                 + CW'(s1_prod[2][2]) - CW'(s1_prod[2][3]);
      s2_acc[3] <= CW'(s1_prod[3][0]) + CW'(s1_prod[3][1])
                 + CW'(s1_prod[3][2]) + CW'(s1_prod[3][3]);
    end
  end

  // Stage 3: output register; a bad pair passes its amplitudes through
  always_ff @(posedge clk) begin
    if (adv) begin
      results.phys_row0   <= s2_item.row0;
      results.phys_row1   <= s2_item.row1;
      results.index_error <= s2_item.bad;
      results.new0_re     <= s2_item.bad ? s2_item.a0r : round_sat(s2_acc[0]);
      results.new0_im     <= s2_item.bad ? s2_item.a0i : round_sat(s2_acc[1]);
      results.new1_re     <= s2_item.bad ? s2_item.a1r : round_sat(s2_acc[2]);
      results.new1_im     <= s2_item.bad ? s2_item.a1i : round_sat(s2_acc[3]);
    end
  end

  assign results.valid = s3_valid;

endmodule

`default_nettype wire

>>> rtl/core/morton_pair_gate_apply_core.sv
// Single-qubit gate update for a state vector held in Morton row order.
// Channel "pairs" (valid/ready) takes one row pair per transfer: the pair
// index and the two Q1.15 complex amplitudes. Channel "results" returns one
// item per pair: both Morton physical rows, the two updated amplitudes and
// an error flag. A bad index or geometry sets index_error, zeroes the rows
// and passes the amplitudes through unchanged.
// Path: the front register is loaded at the input transfer, then the queue
// slot, the product and sum stages and the output stage; the result shows
// on "results" once it is in the output stage.
// Throughput is one pair per cycle while results are taken, set by the fully
// pipelined multiply back end (sixteen 16x16 products per pair).
// When the receiver stalls, the back end holds; the front keeps taking
// pairs until the queue between them fills, then drops ready.
// Reset (rst, synchronous) empties the pipe and queue and loads one qubit,
// target zero and the identity gate. The user must write the registers over
// the APB port only while no pair is in flight; the block does not enforce it.
`default_nettype none

module morton_pair_gate_apply_core #(
  parameter int MAX_QUBITS  = mpga_pkg::MAX_QUBITS_DEF,
  parameter int QUEUE_DEPTH = mpga_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mpga_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mpga_pkg::DATA_W-1:0] pwdata,
  output logic      [mpga_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  mpga_pair_if.sink                        pairs,
  mpga_res_if.source                       results
);

  mpga_pkg::geom_t    geom;
  mpga_pkg::gate_t    gate;
  mpga_pkg::reg_idx_t reg_sel;
  logic               wr_en;

  mpga_pkg::item_t    f_item;
  logic               f_valid;
  logic               f_ready;
  mpga_pkg::item_t    q_item;
  logic               q_valid;
  logic               q_ready;

  assign pready  = 1'b1;
  assign reg_sel = mpga_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      geom.qubit_count  <= mpga_pkg::QUBIT_COUNT_RST;
      geom.tgt_pos      <= mpga_pkg::TARGET_RST;
      gate.c00          <= mpga_pkg::COEF_ONE;
      gate.c01          <= mpga_pkg::COEF_ZERO;
      gate.c10          <= mpga_pkg::COEF_ZERO;
      gate.c11          <= mpga_pkg::COEF_ONE;
    end else if (wr_en) begin
      case (reg_sel)
        mpga_pkg::REG_QUBIT_COUNT:  geom.qubit_count  <= pwdata[mpga_pkg::CNT_W-1:0];
        mpga_pkg::REG_TARGET_QUBIT: geom.tgt_pos      <= pwdata[mpga_pkg::CNT_W-1:0];
        mpga_pkg::REG_COEF_00:      gate.c00          <= pwdata;
        mpga_pkg::REG_COEF_01:      gate.c01          <= pwdata;
        mpga_pkg::REG_COEF_10:      gate.c10          <= pwdata;
        mpga_pkg::REG_COEF_11:      gate.c11          <= pwdata;
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_sel)
      mpga_pkg::REG_QUBIT_COUNT:  prdata = mpga_pkg::DATA_W'(geom.qubit_count);
      mpga_pkg::REG_TARGET_QUBIT: prdata = mpga_pkg::DATA_W'(geom.tgt_pos);
      mpga_pkg::REG_COEF_00:      prdata = gate.c00;
      mpga_pkg::REG_COEF_01:      prdata = gate.c01;
      mpga_pkg::REG_COEF_10:      prdata = gate.c10;
      mpga_pkg::REG_COEF_11:      prdata = gate.c11;
      default:                    prdata = '0;
    endcase
  end

  mpga_front #(
    .MAX_QUBITS (MAX_QUBITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .pairs      (pairs),
    .geom       (geom),
    .item       (f_item),
    .item_valid (f_valid),
    .item_ready (f_ready)
  );

  mpga_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_item  (f_item),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_item   (q_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready)
  );

  mpga_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_item  (q_item),
    .in_valid (q_valid),
    .in_ready (q_ready),
    .gate     (gate),
    .results  (results)
  );

endmodule

`default_nettype wire

>>> bench/morton_pair_gate_apply_core_tb.sv
module morton_pair_gate_apply_core_tb;

  localparam int STALL_LIMIT = 4000;
  localparam int BATCHES     = 5;
  localparam int BATCH_PAIRS = 28;
  localparam int TAIL_CYCLES = 12;

  // Word indexes past the register map; writes there must change nothing
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic [mpga_pkg::PAIR_W-1:0]       pair_index;
    logic signed [mpga_pkg::AMP_W-1:0] a0r;
    logic signed [mpga_pkg::AMP_W-1:0] a0i;
    logic signed [mpga_pkg::AMP_W-1:0] a1r;
    logic signed [mpga_pkg::AMP_W-1:0] a1i;
  } pair_t;

  typedef struct {
    logic [mpga_pkg::ROW_W-1:0]        row0;
    logic [mpga_pkg::ROW_W-1:0]        row1;
    logic signed [mpga_pkg::AMP_W-1:0] n0r;
    logic signed [mpga_pkg::AMP_W-1:0] n0i;
    logic signed [mpga_pkg::AMP_W-1:0] n1r;
    logic signed [mpga_pkg::AMP_W-1:0] n1i;
    logic                              err;
  } outcome_t;

  typedef enum {STEP_REG, STEP_PAIR, STEP_KNOWN} plan_kind_t;

  typedef struct {
    plan_kind_t  kind;
    logic [2:0]  sel;
    logic [31:0] value;
    pair_t       pair;
    outcome_t    known;
  } plan_step_t;

  logic                        clk;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [mpga_pkg::ADDR_W-1:0] paddr;
  logic [mpga_pkg::DATA_W-1:0] pwdata;
  logic [mpga_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  mpga_pair_if pair_ch();
  mpga_res_if  res_ch();

  morton_pair_gate_apply_core u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pairs   (pair_ch),
    .results (res_ch)
  );

  // Shadow copy of the register file
  logic [mpga_pkg::CNT_W-1:0]  qcount;
  logic [mpga_pkg::CNT_W-1:0]  tgt;
  logic [mpga_pkg::COEF_W-1:0] gate_coef [4];

  outcome_t   due_results [$];
  plan_step_t stim_table [$];
  int         send_idle_pct;
  int         recv_stall_pct;
  int         mismatch_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Morton row: low ceil(n/2) bits to even positions, the rest to odd ones
  function automatic logic [63:0] z_interleave(logic [63:0] row, int unsigned n);
    int unsigned lo_bits;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] z;
    lo_bits = (n + 1) / 2;
    lo = row & ((64'd1 << lo_bits) - 64'd1);
    hi = row >> lo_bits;
    z = '0;
    for (int k = 0; k < 32; k++) begin
      z[2*k]   = lo[k];
      z[2*k+1] = hi[k];
    end
    return z;
  endfunction

  // Q3.29 sum back to Q1.15: round half up, then clamp
  function automatic logic signed [mpga_pkg::AMP_W-1:0] round_to_q15(longint acc);
    longint r;
    r = (acc + 64'sd8192) >>> 14;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[mpga_pkg::AMP_W-1:0];
  endfunction

  // One gate row applied to the amplitude pair; {re, im}
  function automatic logic [2*mpga_pkg::AMP_W-1:0] gate_row(
    logic [mpga_pkg::COEF_W-1:0] ga, logic [mpga_pkg::COEF_W-1:0] gb, pair_t p);
    longint gar, gai, gbr, gbi, re, im;
    gar = $signed(ga[31:16]);
    gai = $signed(ga[15:0]);
    gbr = $signed(gb[31:16]);
    gbi = $signed(gb[15:0]);
    re = gar * p.a0r - gai * p.a0i + gbr * p.a1r - gbi * p.a1i;
    im = gar * p.a0i + gai * p.a0r + gbr * p.a1i + gbi * p.a1r;
    return {round_to_q15(re), round_to_q15(im)};
  endfunction

  function automatic outcome_t gate_pair_update(pair_t p);
    outcome_t                     o;
    logic [63:0]                  idx, i0, i1, z0, z1;
    logic [2*mpga_pkg::AMP_W-1:0] top, bot;
    bit                           bad;
    idx = p.pair_index;
    bad = (qcount == 0) || (qcount > mpga_pkg::MAX_QUBITS_DEF) || (tgt >= qcount);
    if (!bad && idx >= (64'd1 << (qcount - 1))) bad = 1'b1;
    if (bad) begin
      o.row0 = '0;
      o.row1 = '0;
      o.n0r  = p.a0r;
      o.n0i  = p.a0i;
      o.n1r  = p.a1r;
      o.n1i  = p.a1i;
      o.err  = 1'b1;
      return o;
    end
    // open a zero bit at the target position
    i0 = ((idx >> tgt) << (tgt + 1)) | (idx & ((64'd1 << tgt) - 64'd1));
    i1 = i0 | (64'd1 << tgt);
    z0 = z_interleave(i0, qcount);
    z1 = z_interleave(i1, qcount);
    top = gate_row(gate_coef[0], gate_coef[1], p);
    bot = gate_row(gate_coef[2], gate_coef[3], p);
    o.row0 = z0[mpga_pkg::ROW_W-1:0];
    o.row1 = z1[mpga_pkg::ROW_W-1:0];
    o.n0r  = top[2*mpga_pkg::AMP_W-1:mpga_pkg::AMP_W];
    o.n0i  = top[mpga_pkg::AMP_W-1:0];
    o.n1r  = bot[2*mpga_pkg::AMP_W-1:mpga_pkg::AMP_W];
    o.n1i  = bot[mpga_pkg::AMP_W-1:0];
    o.err  = 1'b0;
    return o;
  endfunction

  function automatic pair_t mk_pair(logic [mpga_pkg::PAIR_W-1:0] idx, logic [15:0] a0r,
                                    logic [15:0] a0i, logic [15:0] a1r,
                                    logic [15:0] a1i);
    pair_t p;
    p.pair_index = idx;
    p.a0r = a0r;
    p.a0i = a0i;
    p.a1r = a1r;
    p.a1i = a1i;
    return p;
  endfunction

  // Directed plan entries
  function automatic void plan_reg(logic [2:0] sel, logic [31:0] value);
    plan_step_t s;
    s.kind  = STEP_REG;
    s.sel   = sel;
    s.value = value;
    stim_table.push_back(s);
  endfunction

  function automatic void plan_pair(pair_t p);
    plan_step_t s;
    s.kind = STEP_PAIR;
    s.pair = p;
    stim_table.push_back(s);
  endfunction

  // Identity gate or error passthrough: amplitudes come back unchanged
  function automatic void plan_known(pair_t p, logic [mpga_pkg::ROW_W-1:0] row0,
                                     logic [mpga_pkg::ROW_W-1:0] row1, logic err);
    plan_step_t s;
    s.kind       = STEP_KNOWN;
    s.pair       = p;
    s.known.row0 = row0;
    s.known.row1 = row1;
    s.known.n0r  = p.a0r;
    s.known.n0i  = p.a0i;
    s.known.n1r  = p.a1r;
    s.known.n1i  = p.a1i;
    s.known.err  = err;
    stim_table.push_back(s);
  endfunction

  function automatic void apply_reg(logic [2:0] sel, logic [31:0] value);
    case (sel)
      mpga_pkg::REG_QUBIT_COUNT:  qcount = value[mpga_pkg::CNT_W-1:0];
      mpga_pkg::REG_TARGET_QUBIT: tgt = value[mpga_pkg::CNT_W-1:0];
      mpga_pkg::REG_COEF_00:      gate_coef[0] = value;
      mpga_pkg::REG_COEF_01:      gate_coef[1] = value;
      mpga_pkg::REG_COEF_10:      gate_coef[2] = value;
      mpga_pkg::REG_COEF_11:      gate_coef[3] = value;
      default: ;
    endcase
  endfunction

  function automatic logic [15:0] rand_amp();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Coefficient halves: unit, minus unit, plus or minus 1/sqrt2, zero, or anything
  function automatic logic [15:0] rand_coef_half();
    case ($urandom_range(0, 6))
      0: return 16'h4000;
      1: return 16'hC000;
      2: return 16'h2D41;
      3: return 16'hD2BF;
      4: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pair_t random_pair();
    logic [mpga_pkg::PAIR_W-1:0] idx;
    if (qcount >= 1 && qcount <= mpga_pkg::MAX_QUBITS_DEF && $urandom_range(0, 9) != 0)
      idx = mpga_pkg::PAIR_W'($urandom_range(0, (1 << (qcount - 1)) - 1));
    else
      idx = mpga_pkg::PAIR_W'($urandom);
    return mk_pair(idx, rand_amp(), rand_amp(), rand_amp(), rand_amp());
  endfunction

  // APB write: setup phase, access phase until pready, then back to idle
  task automatic write_reg(logic [2:0] sel, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    apply_reg(sel, value);
    @(posedge clk);
  endtask

  // One pair transfer; the expectation is queued once it is accepted
  task automatic send_pair(pair_t p, outcome_t want);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      pair_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    pair_ch.valid      <= 1'b1;
    pair_ch.pair_index <= p.pair_index;
    pair_ch.amp0_re    <= p.a0r;
    pair_ch.amp0_im    <= p.a0i;
    pair_ch.amp1_re    <= p.a1r;
    pair_ch.amp1_im    <= p.a1i;
    do @(posedge clk); while (!pair_ch.ready);
    due_results.push_back(want);
  endtask

  task automatic wait_for_drain();
    pair_ch.valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  task automatic check_field(string name, logic signed [31:0] want,
                             logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Result side: random stalls, compare each transfer with the oldest expectation
  initial begin
    outcome_t want;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        if (due_results.size() == 0) begin
          $error("result transfer with nothing expected");
          mismatch_count++;
        end else begin
          want = due_results.pop_front();
          check_field("phys_row0", want.row0, res_ch.phys_row0);
          check_field("phys_row1", want.row1, res_ch.phys_row1);
          check_field("new0_re", want.n0r, res_ch.new0_re);
          check_field("new0_im", want.n0i, res_ch.new0_im);
          check_field("new1_re", want.n1r, res_ch.new1_re);
          check_field("new1_im", want.n1i, res_ch.new1_im);
          check_field("index_error", want.err, res_ch.index_error);
        end
      end
      res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: too many cycles without any transfer on either channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((pair_ch.valid === 1'b1 && pair_ch.ready === 1'b1) ||
          (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    pair_t p;
    int    n_sel;
    int    t_sel;

    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    pair_ch.valid      <= 1'b0;
    pair_ch.pair_index <= '0;
    pair_ch.amp0_re    <= '0;
    pair_ch.amp0_im    <= '0;
    pair_ch.amp1_re    <= '0;
    pair_ch.amp1_im    <= '0;
    qcount         = mpga_pkg::QUBIT_COUNT_RST;
    tgt            = mpga_pkg::TARGET_RST;
    gate_coef[0]   = mpga_pkg::COEF_ONE;
    gate_coef[1]   = mpga_pkg::COEF_ZERO;
    gate_coef[2]   = mpga_pkg::COEF_ZERO;
    gate_coef[3]   = mpga_pkg::COEF_ONE;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;

    // Reset state: one qubit, target zero, identity gate
    plan_known(mk_pair(19'd0, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF), 20'd0, 20'd1, 1'b0);
    plan_known(mk_pair(19'd0, 16'h0001, 16'hFFFF, 16'h0000, 16'h0000), 20'd0, 20'd1, 1'b0);
    // pair index past the last pair
    plan_known(mk_pair(19'd1, 16'h1234, 16'h8000, 16'h7FFF, 16'hABCD), 20'd0, 20'd0, 1'b1);
    plan_known(mk_pair(19'h7FFFF, 16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA),
               20'd0, 20'd0, 1'b1);
    // widest geometry, target at top and bottom
    plan_reg(mpga_pkg::REG_QUBIT_COUNT, 32'd20);
    plan_reg(mpga_pkg::REG_TARGET_QUBIT, 32'd19);
    plan_pair(mk_pair(19'd0, 16'h4000, 16'hC000, 16'h0001, 16'hFFFF));
    plan_pair(mk_pair(19'h7FFFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000));
    plan_reg(mpga_pkg::REG_TARGET_QUBIT, 32'd0);
    plan_pair(mk_pair(19'h7FFFF, 16'h0100, 16'hFF00, 16'h2000, 16'hE000));
    plan_pair(mk_pair(19'h2AAAA, 16'h1111, 16'h2222, 16'h3333, 16'h4444));
    // target not below the qubit count
    plan_reg(mpga_pkg::REG_TARGET_QUBIT, 32'd20);
    plan_known(mk_pair(19'd3, 16'h0ABC, 16'hF123, 16'h7FFF, 16'h8000), 20'd0, 20'd0, 1'b1);
    plan_reg(mpga_pkg::REG_TARGET_QUBIT, 32'd31);
    plan_known(mk_pair(19'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000), 20'd0, 20'd0, 1'b1);
    // qubit count zero and above the maximum
    plan_reg(mpga_pkg::REG_TARGET_QUBIT, 32'd0);
    plan_reg(mpga_pkg::REG_QUBIT_COUNT, 32'd0);
    plan_known(mk_pair(19'd0, 16'h0001, 16'h0002, 16'h0003, 16'h0004), 20'd0, 20'd0, 1'b1);
    plan_reg(mpga_pkg::REG_QUBIT_COUNT, 32'd21);
    plan_known(mk_pair(19'd0, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h8000), 20'd0, 20'd0, 1'b1);
    plan_reg(mpga_pkg::REG_QUBIT_COUNT, 32'd31);
    plan_known(mk_pair(19'd1, 16'h4321, 16'hBCDE, 16'h0F0F, 16'hF0F0), 20'd0, 20'd0, 1'b1);
    // extreme coefficients drive the sums into saturation
    plan_reg(mpga_pkg::REG_QUBIT_COUNT, 32'd5);
    plan_reg(mpga_pkg::REG_TARGET_QUBIT, 32'd2);
    plan_reg(mpga_pkg::REG_COEF_00, 32'h8000_8000);
    plan_reg(mpga_pkg::REG_COEF_01, 32'h7FFF_7FFF);
    plan_reg(mpga_pkg::REG_COEF_10, 32'h0000_4000);
    plan_reg(mpga_pkg::REG_COEF_11, 32'h8000_0000);
    plan_pair(mk_pair(19'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    plan_pair(mk_pair(19'd15, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    plan_known(mk_pair(19'd16, 16'h7FFF, 16'h8000, 16'h0000, 16'h0001), 20'd0, 20'd0, 1'b1);
    plan_pair(mk_pair(19'd5, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000));
    // halves land exactly on the rounding midpoint
    plan_reg(mpga_pkg::REG_COEF_00, 32'h2000_0000);
    plan_reg(mpga_pkg::REG_COEF_01, 32'h0000_0000);
    plan_reg(mpga_pkg::REG_COEF_10, 32'h0000_0000);
    plan_reg(mpga_pkg::REG_COEF_11, 32'hE000_0000);
    plan_pair(mk_pair(19'd3, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF));
    plan_pair(mk_pair(19'd3, 16'h0003, 16'hFFFD, 16'h0005, 16'hFFFB));
    // writes past the register map leave everything as it was
    plan_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    plan_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
    plan_pair(mk_pair(19'd7, 16'h0001, 16'h8000, 16'h7FFF, 16'hFFFF));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[k]) begin
      case (stim_table[k].kind)
        STEP_REG: begin
          wait_for_drain();
          write_reg(stim_table[k].sel, stim_table[k].value);
        end
        STEP_PAIR: send_pair(stim_table[k].pair, gate_pair_update(stim_table[k].pair));
        default: send_pair(stim_table[k].pair, stim_table[k].known);
      endcase
    end

    // Random batches over four idling mixes; new geometry and gate per batch
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      for (int b = 0; b < BATCHES; b++) begin
        if (b == 0) n_sel = mpga_pkg::MAX_QUBITS_DEF;
        else if (b == 1) n_sel = 1;
        else if ($urandom_range(0, 7) == 0) n_sel = $urandom_range(0, 31);
        else n_sel = $urandom_range(2, 19);
        if (n_sel >= 1 && n_sel <= mpga_pkg::MAX_QUBITS_DEF && $urandom_range(0, 9) != 0)
          t_sel = $urandom_range(0, n_sel - 1);
        else
          t_sel = $urandom_range(0, 31);
        wait_for_drain();
        write_reg(mpga_pkg::REG_QUBIT_COUNT, 32'(n_sel));
        write_reg(mpga_pkg::REG_TARGET_QUBIT, 32'(t_sel));
        write_reg(mpga_pkg::REG_COEF_00, {rand_coef_half(), rand_coef_half()});
        write_reg(mpga_pkg::REG_COEF_01, {rand_coef_half(), rand_coef_half()});
        write_reg(mpga_pkg::REG_COEF_10, {rand_coef_half(), rand_coef_half()});
        write_reg(mpga_pkg::REG_COEF_11, {rand_coef_half(), rand_coef_half()});
        repeat (BATCH_PAIRS) begin
          p = random_pair();
          send_pair(p, gate_pair_update(p));
        end
      end
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
